>>> rtl/sle_pkg.sv
// Package for the sorted list engine: payload structs, operation and
// status codes, and the control struct broadcast to the row of cells.
// No dependencies.
`default_nettype none

package sle_pkg;

   localparam int DATA_W    = 32;
   localparam int OP_W      = 3;
   localparam int STATUS_W  = 3;
   localparam int HELD_W    = 5;
   localparam int MODE_W    = 2;

   localparam logic [OP_W-1:0] OP_INSERT     = 3'd0;
   localparam logic [OP_W-1:0] OP_DEL_VALUE  = 3'd1;
   localparam logic [OP_W-1:0] OP_DEL_MIN    = 3'd2;
   localparam logic [OP_W-1:0] OP_DEL_MAX    = 3'd3;
   localparam logic [OP_W-1:0] OP_READ_OUT   = 3'd4;

   localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
   localparam logic [STATUS_W-1:0] ST_DELETED  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd2;
   localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd3;
   localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;
   localparam logic [STATUS_W-1:0] ST_LISTED   = 3'd5;

   // What every cell does in a cycle.
   localparam logic [MODE_W-1:0] MODE_HOLD   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_INSERT = 2'd1;
   localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;
   localparam logic [MODE_W-1:0] MODE_ROTATE = 2'd3;

   typedef struct packed {
      logic [OP_W-1:0]          op;
      logic signed [DATA_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]      status;
      logic signed [DATA_W-1:0] item;
      logic [HELD_W-1:0]        entries_held;
      logic                     last;
   } rsp_type;

   typedef struct packed {
      logic [MODE_W-1:0]        mode;
      logic signed [DATA_W-1:0] value;
      logic [DATA_W-1:0]        head;
   } cell_ctrl_type;

endpackage

`default_nettype wire

>>> rtl/sorted_list_engine_unit.sv
// Top level of the sorted list engine: a row of sle_cell instances and the
// control that sequences them. Depends on sle_pkg and sle_cell.
//
// Usage: an operation is transferred at a rising edge where start is high
// and busy is low; req_data carries the op code and the value. Results
// appear on rsp_data for exactly one cycle, marked by rsp_valid, and are
// taken at the edge that ends that cycle; the receiver cannot stall them.
// Insert, delete-value, delete-smallest and delete-largest keep busy low:
// each cell compares its slot with the value in parallel and shifts toward
// or away from its neighbor (delete-largest only drops the tail cell), so
// one of these ops can be transferred every cycle and its single result
// shows in the cycle after the transfer. Read-out on a non-empty list
// rotates the row by one cell per cycle and emits the head each cycle, so
// it gives one result per entry held, on consecutive cycles; the first
// comes once busy has risen and the head is registered. Busy stays high
// while listing, and the row is back in order when it drops.
// An empty list answers any delete or read-out with one empty result.
// Undefined op codes are taken and give no result. Reset empties the list;
// the slots keep whatever they held and are never shown before being written.
`default_nettype none

module sorted_list_engine_unit #(
   parameter int CAPACITY = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire sle_pkg::req_type req_data,
   output logic                  busy,
   output logic                  rsp_valid,
   output sle_pkg::rsp_type      rsp_data
);

   localparam int OCC_W = $clog2(CAPACITY + 1);
   localparam int DW    = sle_pkg::DATA_W;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_LIST = 1'b1;

   logic                  state_ff, state_in;
   logic [OCC_W-1:0]      occ_ff, occ_in;
   logic [OCC_W-1:0]      cnt_ff, cnt_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   sle_pkg::rsp_type      rsp_data_ff, rsp_data_in;

   sle_pkg::cell_ctrl_type ctrl;
   logic [DW-1:0]          slot_vec [CAPACITY];
   logic [DW-1:0]          tail_vec [CAPACITY];
   logic [CAPACITY-1:0]    ins_vec;
   logic [CAPACITY-1:0]    match_vec;
   logic [CAPACITY-1:0]    lowbit;
   logic [CAPACITY-1:0]    rm_match;
   logic [CAPACITY-1:0]    rm_vec;
   logic [DW-1:0]          tail_val;
   logic                   found;
   logic                   accept;
   logic                   list_last;
   logic [OCC_W+sle_pkg::HELD_W-1:0] occ_ext;

   assign accept = start && !busy;
   assign busy   = state_ff == ST_LIST;

   genvar gi;
   generate
      for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
         logic [DW-1:0] left_slot;
         logic          left_ins;
         logic [DW-1:0] right_slot;
         if (gi == 0) begin : g_first
            assign left_slot = '0;
            assign left_ins  = 1'b0;
         end else begin : g_mid
            assign left_slot = slot_vec[gi-1];
            assign left_ins  = ins_vec[gi-1];
         end
         if (gi == CAPACITY - 1) begin : g_end
            assign right_slot = slot_vec[gi];
         end else begin : g_inner
            assign right_slot = slot_vec[gi+1];
         end
         sle_cell #(
            .IDX   (gi),
            .OCC_W (OCC_W)
         ) u_cell (
            .clock      (clock),
            .ctrl       (ctrl),
            .occ        (occ_ff),
            .left_slot  (left_slot),
            .left_ins   (left_ins),
            .right_slot (right_slot),
            .rm         (rm_vec[gi]),
            .slot       (slot_vec[gi]),
            .ins        (ins_vec[gi]),
            .match      (match_vec[gi]),
            .tail_slot  (tail_vec[gi])
         );
      end
   endgenerate

   // The first matching cell and every cell after it pull from the right.
   assign found    = |match_vec;
   assign lowbit   = match_vec & (~match_vec + 1'b1);
   assign rm_match = ~(lowbit - 1'b1);

   always_comb begin
      tail_val = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         tail_val = tail_val | tail_vec[i];
      end
   end

   assign list_last = (cnt_ff + 1'b1) == occ_ff;

   always_comb begin
      ctrl.mode    = sle_pkg::MODE_HOLD;
      ctrl.value   = req_data.value;
      ctrl.head    = slot_vec[0];
      rm_vec       = rm_match;
      occ_in       = occ_ff;
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      rsp_data_in.last = 1'b1;

      if (state_ff == ST_LIST) begin
         ctrl.mode           = sle_pkg::MODE_ROTATE;
         rsp_valid_in        = 1'b1;
         rsp_data_in.status  = sle_pkg::ST_LISTED;
         rsp_data_in.item    = slot_vec[0];
         rsp_data_in.last    = list_last;
         cnt_in              = cnt_ff + 1'b1;
         if (list_last) begin
            state_in = ST_IDLE;
         end
      end else if (accept) begin
         rsp_data_in.item = req_data.value;
         unique case (req_data.op)
            sle_pkg::OP_INSERT: begin
               rsp_valid_in = 1'b1;
               if (occ_ff == OCC_W'(CAPACITY)) begin
                  rsp_data_in.status = sle_pkg::ST_FULL;
               end else begin
                  ctrl.mode          = sle_pkg::MODE_INSERT;
                  occ_in             = occ_ff + 1'b1;
                  rsp_data_in.status = sle_pkg::ST_INSERTED;
               end
            end
            sle_pkg::OP_DEL_VALUE, sle_pkg::OP_DEL_MIN, sle_pkg::OP_DEL_MAX: begin
               rsp_valid_in = 1'b1;
               if (occ_ff == '0) begin
                  rsp_data_in.status = sle_pkg::ST_EMPTY;
                  rsp_data_in.item   = '0;
               end else if (req_data.op == sle_pkg::OP_DEL_VALUE) begin
                  if (found) begin
                     ctrl.mode          = sle_pkg::MODE_REMOVE;
                     occ_in             = occ_ff - 1'b1;
                     rsp_data_in.status = sle_pkg::ST_DELETED;
                  end else begin
                     rsp_data_in.status = sle_pkg::ST_NOTFOUND;
                  end
               end else if (req_data.op == sle_pkg::OP_DEL_MIN) begin
                  ctrl.mode          = sle_pkg::MODE_REMOVE;
                  rm_vec             = '1;
                  occ_in             = occ_ff - 1'b1;
                  rsp_data_in.status = sle_pkg::ST_DELETED;
                  rsp_data_in.item   = slot_vec[0];
               end else begin
                  // The tail cell drops out when the count shrinks.
                  occ_in             = occ_ff - 1'b1;
                  rsp_data_in.status = sle_pkg::ST_DELETED;
                  rsp_data_in.item   = tail_val;
               end
            end
            sle_pkg::OP_READ_OUT: begin
               if (occ_ff == '0) begin
                  rsp_valid_in       = 1'b1;
                  rsp_data_in.status = sle_pkg::ST_EMPTY;
                  rsp_data_in.item   = '0;
               end else begin
                  state_in = ST_LIST;
                  cnt_in   = '0;
               end
            end
            default: begin
               rsp_valid_in = 1'b0;
            end
         endcase
      end

      occ_ext                  = (OCC_W + sle_pkg::HELD_W)'(occ_in);
      rsp_data_in.entries_held = occ_ext[sle_pkg::HELD_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         occ_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         occ_ff       <= occ_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

>>> rtl/sle_cell.sv
// One cell of the sorted list: holds a single slot and moves data to or
// from its neighbors. Depends on sle_pkg.
`default_nettype none

module sle_cell #(
   parameter int IDX   = 0,
   parameter int OCC_W = 5
) (
   input  wire logic                          clock,
   input  wire sle_pkg::cell_ctrl_type        ctrl,
   input  wire logic [OCC_W-1:0]              occ,
   input  wire logic [sle_pkg::DATA_W-1:0]    left_slot,
   input  wire logic                          left_ins,
   input  wire logic [sle_pkg::DATA_W-1:0]    right_slot,
   input  wire logic                          rm,
   output logic [sle_pkg::DATA_W-1:0]         slot,
   output logic                               ins,
   output logic                               match,
   output logic [sle_pkg::DATA_W-1:0]         tail_slot
);

   logic [sle_pkg::DATA_W-1:0] slot_ff;
   logic [sle_pkg::DATA_W-1:0] slot_in;
   logic                       valid;
   logic                       is_tail;

   assign valid   = OCC_W'(IDX) < occ;
   assign is_tail = OCC_W'(IDX + 1) == occ;

   // Because the list is sorted and packed, ins is low for a prefix of the
   // cells and high for the rest; the first high cell takes the new value.
   assign ins       = !valid || ($signed(slot_ff) > ctrl.value);
   assign match     = valid && (slot_ff == ctrl.value);
   assign slot      = slot_ff;
   assign tail_slot = is_tail ? slot_ff : '0;

   always_comb begin
      slot_in = slot_ff;
      unique case (ctrl.mode)
         sle_pkg::MODE_HOLD: begin
            slot_in = slot_ff;
         end
         sle_pkg::MODE_INSERT: begin
            if (ins) begin
               slot_in = left_ins ? left_slot : ctrl.value;
            end
         end
         sle_pkg::MODE_REMOVE: begin
            if (rm) begin
               slot_in = right_slot;
            end
         end
         sle_pkg::MODE_ROTATE: begin
            slot_in = is_tail ? ctrl.head : right_slot;
         end
         default: begin
            slot_in = slot_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

endmodule

`default_nettype wire

>>> rtl/sle_checker.sv
// Port-level checks for the sorted list engine and the bind that attaches
// them to sorted_list_engine_unit. Depends on sle_pkg.
`default_nettype none

module sle_checker #(
   parameter int CAPACITY = 16
) (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             busy,
   input wire logic             rsp_valid,
   input wire sle_pkg::rsp_type rsp_data
);

   localparam int HELD_EXT = sle_pkg::HELD_W + 8;
   localparam logic [HELD_EXT-1:0] CAP_EXT = HELD_EXT'(CAPACITY);

   // Every read-out cycle produces a listed entry in the next cycle.
   a_busy_emits: assert property (@(posedge clock) disable iff (reset)
      busy |=> (rsp_valid && rsp_data.status == sle_pkg::ST_LISTED))
      else $error("read-out cycle gave no listed entry");

   // Only listed entries can be followed by more results of the same op.
   a_single_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != sle_pkg::ST_LISTED) |-> rsp_data.last)
      else $error("status result without last flag");

   // A listing that is not finished keeps going with the same count.
   a_list_runs: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == sle_pkg::ST_LISTED && !rsp_data.last) |=>
      (rsp_valid && rsp_data.status == sle_pkg::ST_LISTED &&
       $stable(rsp_data.entries_held)))
      else $error("listing broke off early");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == sle_pkg::ST_EMPTY) |->
      (rsp_data.entries_held == '0 && rsp_data.item == '0))
      else $error("empty result with entries or item");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == sle_pkg::ST_FULL) |->
      (rsp_data.entries_held == CAP_EXT[sle_pkg::HELD_W-1:0]))
      else $error("full result with wrong count");

endmodule

bind sorted_list_engine_unit sle_checker #(
   .CAPACITY (CAPACITY)
) u_sle_checker (
   .clock     (clock),
   .reset     (reset),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);

`default_nettype wire
